[design/upv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upv_pkg
// Constants, types and the codepoint range check for the printable UTF-8
// string validator.
// ----------------------------------------------------------------------------
package upv_pkg;

  typedef logic [20:0] codepoint_t;

  typedef enum logic [1:0] {
    CLS_ONE   = 2'd0,
    CLS_TWO   = 2'd1,
    CLS_THREE = 2'd2,
    CLS_FOUR  = 2'd3
  } lead_class_t;

  localparam logic [4:0]  LEAD2_DATA_MASK = 5'h1f;
  localparam logic [3:0]  LEAD3_DATA_MASK = 4'hf;
  localparam logic [2:0]  LEAD4_DATA_MASK = 3'h7;

  localparam codepoint_t MIN_TWO      = 21'h00080;
  localparam codepoint_t MIN_THREE    = 21'h00800;
  localparam codepoint_t MIN_FOUR     = 21'h10000;
  localparam codepoint_t MAX_CP       = 21'h10ffff;
  localparam codepoint_t SURR_LO      = 21'h0d800;
  localparam codepoint_t SURR_HI      = 21'h0dfff;
  localparam codepoint_t PRINT_MIN    = 21'h00020;
  localparam codepoint_t CTRL_HI_LO   = 21'h0007f;
  localparam codepoint_t CTRL_HI_HI   = 21'h0009f;

  function automatic logic cp_ok(input codepoint_t cp, input lead_class_t cls);
    codepoint_t min_cp;
    case (cls)
      CLS_ONE:   min_cp = '0;
      CLS_TWO:   min_cp = MIN_TWO;
      CLS_THREE: min_cp = MIN_THREE;
      CLS_FOUR:  min_cp = MIN_FOUR;
      default:   min_cp = '0;
    endcase
    cp_ok = (cp >= min_cp) && (cp <= MAX_CP) &&
            !((cp >= SURR_LO) && (cp <= SURR_HI)) &&
            (cp >= PRINT_MIN) &&
            !((cp >= CTRL_HI_LO) && (cp <= CTRL_HI_HI));
  endfunction

endpackage

[design/utf8_printable_validator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_printable_validator
// Checks a byte stream string for valid, printable UTF-8 and gives one
// verdict per string.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one word per string byte,
//   text_byte plus final_byte, which marks the last byte of a string.
//   Output channel (out_valid / out_stall): one word per string,
//   string_valid = 1 when the whole string decoded as printable UTF-8.
//   Bytes land in an input register; the decoder updates its state from
//   that register and loads the verdict into an output register, whose
//   out_valid flag marks the verdict as ready to be taken.
//   Throughput is one byte per cycle while in_stall is low; the decoder
//   state update is a single register-to-register step.
//   While out_stall holds a verdict in the output register, non-final bytes
//   still pass through the decoder; a final byte waits in the input register
//   and in_stall rises until the output register frees up.
//   Reset (rst, synchronous) empties both registers and clears the decoder
//   state; the first byte after reset starts a new string.
// ----------------------------------------------------------------------------
module utf8_printable_validator (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] text_byte,
  input  logic       final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       string_valid
);
  import upv_pkg::*;

  logic        held_valid;
  logic [7:0]  held_byte;
  logic        held_final;

  logic [1:0]  pending;
  codepoint_t  codepoint;
  lead_class_t lead_class;
  logic        error_seen;

  logic [1:0]  pending_next;
  codepoint_t  codepoint_next;
  lead_class_t lead_class_next;
  logic        error_next;
  codepoint_t  cp_shift;
  logic        verdict;
  logic        advance;

  assign advance  = held_valid && (!held_final || !out_valid || !out_stall);
  assign in_stall = held_valid && !advance;

  always_comb begin
    pending_next    = pending;
    codepoint_next  = codepoint;
    lead_class_next = lead_class;
    error_next      = error_seen;
    cp_shift        = {codepoint[14:0], held_byte[5:0]};
    if (!error_seen) begin
      if (pending == 2'd0) begin
        if (!held_byte[7]) begin
          if (!cp_ok({13'd0, held_byte}, CLS_ONE)) begin
            error_next = 1'b1;
          end
        end else if (held_byte inside {[8'hc0:8'hdf]}) begin
          codepoint_next  = {16'd0, held_byte[4:0] & LEAD2_DATA_MASK};
          lead_class_next = CLS_TWO;
          pending_next    = 2'd1;
        end else if (held_byte inside {[8'he0:8'hef]}) begin
          codepoint_next  = {17'd0, held_byte[3:0] & LEAD3_DATA_MASK};
          lead_class_next = CLS_THREE;
          pending_next    = 2'd2;
        end else if (held_byte inside {[8'hf0:8'hf7]}) begin
          codepoint_next  = {18'd0, held_byte[2:0] & LEAD4_DATA_MASK};
          lead_class_next = CLS_FOUR;
          pending_next    = 2'd3;
        end else begin
          error_next = 1'b1;
        end
      end else begin
        if (held_byte[7:6] != 2'b10) begin
          error_next = 1'b1;
        end else begin
          codepoint_next = cp_shift;
          pending_next   = pending - 2'd1;
          if ((pending_next == 2'd0) && !cp_ok(cp_shift, lead_class)) begin
            error_next = 1'b1;
          end
        end
      end
    end
    verdict = !error_next && (pending_next == 2'd0);
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_byte  <= text_byte;
      held_final <= final_byte;
    end
  end

  // decoder state, cleared after each final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= 2'd0;
      codepoint  <= '0;
      lead_class <= CLS_ONE;
      error_seen <= 1'b0;
    end else if (advance) begin
      if (held_final) begin
        pending    <= 2'd0;
        codepoint  <= '0;
        lead_class <= CLS_ONE;
        error_seen <= 1'b0;
      end else begin
        pending    <= pending_next;
        codepoint  <= codepoint_next;
        lead_class <= lead_class_next;
        error_seen <= error_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && held_final) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && held_final) begin
      string_valid <= verdict;
    end
  end

  // continuations pending only inside a multibyte form
  assert property (@(posedge clk) disable iff (rst)
    (pending != 2'd0) |-> (lead_class != CLS_ONE) && (pending <= lead_class))
    else $error("pending count exceeds lead form");

  // a final byte leaves the decoder cleared
  assert property (@(posedge clk) disable iff (rst)
    (advance && held_final) |=> (pending == 2'd0) && !error_seen)
    else $error("decoder state not cleared after final byte");

  // an error before the final byte or a cut-off sequence yields an invalid verdict
  assert property (@(posedge clk) disable iff (rst)
    (advance && held_final && (error_seen || (pending_next != 2'd0)))
      |=> out_valid && !string_valid)
    else $error("invalid string reported as valid");

  // input register holds only when a verdict is blocked
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> held_final && out_valid && out_stall)
    else $error("input stalled without a blocked verdict");

endmodule
